// ===== design/setup_code_from_mac_unit_assert.svh =====
// Assertion macros for the setup-code generator.
// Used by setup_code_from_mac_unit; expects clk and rst_n in scope.
`ifndef SETUP_CODE_FROM_MAC_UNIT_ASSERT_SVH
`define SETUP_CODE_FROM_MAC_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SCM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("setup code assertion failed");

// Next-cycle implication, checked outside reset.
`define SCM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("setup code assertion failed");

`endif

// ===== design/scm_pkg.sv =====
// Package for the setup-code generator: constants and per-stage functions.
// No dependencies; imported by setup_code_from_mac_unit.
package scm_pkg;

  localparam int unsigned REJECT_TRIES_DEF = 16;

  localparam logic [31:0] FNV_BASIS     = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME     = 32'd16777619;
  localparam logic [31:0] CODE_MOD      = 32'd100000000;
  localparam logic [26:0] CODE_MOD_27   = 27'd100000000;
  localparam logic [26:0] CODE_STEP     = 27'd7919;
  localparam logic [26:0] REPDIGIT      = 27'd11111111;
  localparam logic [26:0] BANNED_ASC    = 27'd12345678;
  localparam logic [26:0] BANNED_DESC   = 27'd87654321;
  localparam logic [26:0] FALLBACK_CODE = 27'd41827693;

  // Reciprocals for the digit split; exact for codes below 10^8.
  localparam logic [27:0] RECIP_1000 = 28'd137438954;  // ceil(2^37 / 1000)
  localparam logic [17:0] RECIP_100  = 18'd167773;     // ceil(2^24 / 100)

  // One FNV-1a round: xor in a byte, multiply by the prime modulo 2^32.
  function automatic logic [31:0] fnv_round(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x * FNV_PRIME;
  endfunction

  // Conditional subtract used by the modulo reduction.
  function automatic logic [31:0] sub_if_ge(input logic [31:0] v, input logic [31:0] d);
    return (v >= d) ? (v - d) : v;
  endfunction

  // Zero, the eight-digit repdigits, and the two digit runs.
  function automatic logic code_banned(input logic [26:0] c);
    logic hit;
    hit = (c == BANNED_ASC) || (c == BANNED_DESC);
    for (int k = 0; k < 10; k++) begin
      hit = hit | (c == 27'(k * 11111111));
    end
    return hit;
  endfunction

  // One rejection step: add the step modulo 10^8 when the code is banned.
  function automatic logic [26:0] reject_step(input logic [26:0] c);
    logic [27:0] s;
    s = {1'b0, c} + {1'b0, CODE_STEP};
    if (s >= {1'b0, CODE_MOD_27}) begin
      s = s - {1'b0, CODE_MOD_27};
    end
    return code_banned(c) ? s[26:0] : c;
  endfunction

endpackage

// ===== design/setup_code_from_mac_unit.sv =====
// Setup-code generator top level: FNV-1a hash, modulo, rejection and digit split.
// Depends on scm_pkg and setup_code_from_mac_unit_assert.svh.
//
// Usage: a request on the in_ channel carries a 48-bit MAC address (first byte
// in bits 47..40) and an availability flag. Each request yields exactly one
// result on the out_ channel: the eight-digit code as a binary number, its
// three decimal groups, and a flag that tells whether the fixed fallback code
// was used because no MAC was available.
// One request can enter every cycle while in_stall is low; the depth is set
// by one hash round per stage, two compare-subtract steps of the modulo per
// stage, one rejection step per stage and five stages of digit split.
// The whole pipeline advances together. While out_valid is high and out_stall
// is asserted, in_stall rises, nothing moves and every staged request holds.
// Reset (rst_n low, synchronous) clears all valid bits; payload registers keep
// whatever they hold and are ignored until their valid bit is set again.
`include "setup_code_from_mac_unit_assert.svh"

module setup_code_from_mac_unit
  import scm_pkg::*;
#(
  parameter int unsigned REJECT_TRIES = REJECT_TRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [47:0] in_mac_address,
  input  logic        in_mac_available,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [26:0] out_code_value,
  output logic [9:0]  out_first_group,
  output logic [6:0]  out_middle_group,
  output logic [9:0]  out_last_group,
  output logic        out_used_fallback
);

  // Global advance: every stage moves unless a finished result is held.
  logic adv;
  assign in_stall = out_valid && out_stall;
  assign adv      = !in_stall;

  // ---------------------------------------------------------------------
  // Hash section: one FNV-1a round per stage, six stages.
  // ---------------------------------------------------------------------
  logic [47:0] hs_mac_r  [0:5];
  logic [31:0] hs_hash_r [0:5];
  logic        hs_av_r   [0:5];
  logic        hs_v_r    [0:5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_v_r[0] <= 1'b0;
    end else if (adv) begin
      hs_v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hs_mac_r[0]  <= in_mac_address;
      hs_av_r[0]   <= in_mac_available;
      hs_hash_r[0] <= fnv_round(FNV_BASIS, in_mac_address[47:40]);
    end
  end

  for (genvar g = 1; g < 6; g++) begin : g_hash
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        hs_v_r[g] <= 1'b0;
      end else if (adv) begin
        hs_v_r[g] <= hs_v_r[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        hs_mac_r[g]  <= hs_mac_r[g-1];
        hs_av_r[g]   <= hs_av_r[g-1];
        hs_hash_r[g] <= fnv_round(hs_hash_r[g-1], hs_mac_r[g-1][47-8*g -: 8]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Modulo 10^8: binary long division of the quotient (at most 42), two
  // compare-subtract steps per stage over three stages.
  // ---------------------------------------------------------------------
  logic [31:0] md_val_r [0:2];
  logic        md_av_r  [0:2];
  logic        md_v_r   [0:2];

  for (genvar g = 0; g < 3; g++) begin : g_mod
    localparam logic [31:0] D_HI = CODE_MOD << (5 - 2 * g);
    localparam logic [31:0] D_LO = CODE_MOD << (4 - 2 * g);
    logic [31:0] src_val;
    logic        src_av;
    logic        src_v;

    if (g == 0) begin : g_first
      assign src_val = hs_hash_r[5];
      assign src_av  = hs_av_r[5];
      assign src_v   = hs_v_r[5];
    end else begin : g_rest
      assign src_val = md_val_r[g-1];
      assign src_av  = md_av_r[g-1];
      assign src_v   = md_v_r[g-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        md_v_r[g] <= 1'b0;
      end else if (adv) begin
        md_v_r[g] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        md_av_r[g]  <= src_av;
        md_val_r[g] <= sub_if_ge(sub_if_ge(src_val, D_HI), D_LO);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Rejection: one stage per try. A code that is not banned passes through.
  // ---------------------------------------------------------------------
  logic [26:0] rj_code [0:REJECT_TRIES];
  logic        rj_av   [0:REJECT_TRIES];
  logic        rj_v    [0:REJECT_TRIES];

  assign rj_code[0] = md_val_r[2][26:0];
  assign rj_av[0]   = md_av_r[2];
  assign rj_v[0]    = md_v_r[2];

  for (genvar g = 0; g < REJECT_TRIES; g++) begin : g_reject
    logic [26:0] code_r;
    logic        av_r;
    logic        v_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (adv) begin
        v_r <= rj_v[g];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        av_r   <= rj_av[g];
        code_r <= reject_step(rj_code[g]);
      end
    end

    assign rj_code[g+1] = code_r;
    assign rj_av[g+1]   = av_r;
    assign rj_v[g+1]    = v_r;
  end

  // ---------------------------------------------------------------------
  // Fallback selection and decimal split by reciprocal multiplication.
  // ---------------------------------------------------------------------
  logic [26:0] sel_code;
  assign sel_code = rj_av[REJECT_TRIES] ? rj_code[REJECT_TRIES] : FALLBACK_CODE;

  // Stage A: code times the reciprocal of 1000.
  logic [26:0] sa_code_r;
  logic [54:0] sa_prod_r;
  logic        sa_fb_r;
  logic        sa_v_r;

  // Stage B: quotient by 1000 and the last three digits.
  logic [26:0] sb_code_r;
  logic [16:0] sb_q_r;
  logic [9:0]  sb_last_r;
  logic        sb_fb_r;
  logic        sb_v_r;

  // Stage C: quotient times the reciprocal of 100.
  logic [26:0] sc_code_r;
  logic [16:0] sc_q_r;
  logic [34:0] sc_prod_r;
  logic [9:0]  sc_last_r;
  logic        sc_fb_r;
  logic        sc_v_r;

  // Stage D: first group ready; middle group follows in the output stage.
  logic [26:0] sd_code_r;
  logic [16:0] sd_q_r;
  logic [9:0]  sd_first_r;
  logic [9:0]  sd_last_r;
  logic        sd_fb_r;
  logic        sd_v_r;

  // Output register.
  logic [26:0] out_code_r;
  logic [9:0]  out_first_r;
  logic [6:0]  out_mid_r;
  logic [9:0]  out_last_r;
  logic        out_fb_r;
  logic        out_v_r;

  logic [26:0] sb_rem;
  logic [16:0] sd_mid;
  assign sb_rem = sa_code_r - (27'(sa_prod_r[53:37]) * 27'd1000);
  assign sd_mid = sd_q_r - (17'(sd_first_r) * 17'd100);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_v_r  <= 1'b0;
      sb_v_r  <= 1'b0;
      sc_v_r  <= 1'b0;
      sd_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      sa_v_r  <= rj_v[REJECT_TRIES];
      sb_v_r  <= sa_v_r;
      sc_v_r  <= sb_v_r;
      sd_v_r  <= sc_v_r;
      out_v_r <= sd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa_code_r   <= sel_code;
      sa_prod_r   <= sel_code * RECIP_1000;
      sa_fb_r     <= !rj_av[REJECT_TRIES];

      sb_code_r   <= sa_code_r;
      sb_q_r      <= sa_prod_r[53:37];
      sb_last_r   <= sb_rem[9:0];
      sb_fb_r     <= sa_fb_r;

      sc_code_r   <= sb_code_r;
      sc_q_r      <= sb_q_r;
      sc_prod_r   <= sb_q_r * RECIP_100;
      sc_last_r   <= sb_last_r;
      sc_fb_r     <= sb_fb_r;

      sd_code_r   <= sc_code_r;
      sd_q_r      <= sc_q_r;
      sd_first_r  <= sc_prod_r[33:24];
      sd_last_r   <= sc_last_r;
      sd_fb_r     <= sc_fb_r;

      out_code_r  <= sd_code_r;
      out_first_r <= sd_first_r;
      out_mid_r   <= sd_mid[6:0];
      out_last_r  <= sd_last_r;
      out_fb_r    <= sd_fb_r;
    end
  end

  assign out_valid         = out_v_r;
  assign out_code_value    = out_code_r;
  assign out_first_group   = out_first_r;
  assign out_middle_group  = out_mid_r;
  assign out_last_group    = out_last_r;
  assign out_used_fallback = out_fb_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // The three groups put back together must give the code itself.
  logic [31:0] grp_sum;
  assign grp_sum = 32'(out_first_group) * 32'd100000
                 + 32'(out_middle_group) * 32'd1000
                 + 32'(out_last_group);

  `SCM_ASSERT_NOW(a_code_range, out_valid, out_code_value < CODE_MOD_27)
  `SCM_ASSERT_NOW(a_groups_match, out_valid, grp_sum == 32'(out_code_value))
  `SCM_ASSERT_NOW(a_fallback_code, out_valid && out_used_fallback, out_code_value == FALLBACK_CODE)
  `SCM_ASSERT_NEXT(a_hold_when_stalled, in_stall, out_valid && (out_code_value == $past(out_code_value)))

endmodule

// ===== verif/tb_setup_code_from_mac_unit.sv =====
`timescale 1ns / 1ps
// Testbench for setup_code_from_mac_unit: FNV-1a MAC hash to decimal setup code.
// Depends on scm_pkg (for REJECT_TRIES_DEF only) and the RTL; prediction is computed locally.

module tb_setup_code_from_mac_unit;
  import scm_pkg::*;

  // Expected result of one request, one entry per accepted request.
  typedef struct packed {
    logic [26:0] code;
    logic [9:0]  first;
    logic [6:0]  middle;
    logic [9:0]  last;
    logic        fallback;
  } setup_code_t;

  // One pending request for the driver.
  typedef struct packed {
    logic [47:0] mac;
    logic        avail;
  } mac_req_t;

  localparam int unsigned TRIES = REJECT_TRIES_DEF;
  localparam int unsigned N_RANDOM = 650;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [47:0] in_mac_address;
  logic        in_mac_available;
  logic        out_valid;
  logic        out_stall;
  logic [26:0] out_code_value;
  logic [9:0]  out_first_group;
  logic [6:0]  out_middle_group;
  logic [9:0]  out_last_group;
  logic        out_used_fallback;

  mac_req_t    pending_reqs[$];
  setup_code_t expected_codes[$];
  int unsigned mismatches;
  bit          stim_done;
  bit          in_fire;

  setup_code_from_mac_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mac_address   (in_mac_address),
    .in_mac_available (in_mac_available),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_code_value   (out_code_value),
    .out_first_group  (out_first_group),
    .out_middle_group (out_middle_group),
    .out_last_group   (out_last_group),
    .out_used_fallback(out_used_fallback)
  );

  // Banned codes: the two digit runs plus every multiple of 11111111 up to
  // 99999999, which covers zero and all eight-digit repdigits.
  function automatic bit is_banned_code(input logic [31:0] c);
    return (c == 32'd12345678) || (c == 32'd87654321) ||
           ((c % 32'd11111111) == 0 && c <= 32'd99999999);
  endfunction

  // Full predictor: hash, reduce, walk past banned codes, split into digits.
  function automatic setup_code_t predict_setup_code(input mac_req_t r);
    setup_code_t res;
    logic [31:0] h;
    logic [63:0] prod;
    logic [31:0] code;
    int t;
    if (!r.avail) begin
      code = 32'd41827693;
      res.fallback = 1'b1;
    end else begin
      h = 32'd2166136261;
      for (int i = 5; i >= 0; i--) begin
        h = h ^ {24'd0, r.mac[i*8 +: 8]};
        prod = 64'(h) * 64'd16777619;
        h = prod[31:0];
      end
      code = h % 32'd100000000;
      t = 0;
      while (t < TRIES && is_banned_code(code)) begin
        code = (code + 32'd7919) % 32'd100000000;
        t++;
      end
      res.fallback = 1'b0;
    end
    res.code   = code[26:0];
    res.first  = 10'(code / 32'd100000);
    res.middle = 7'((code / 32'd1000) % 32'd100);
    res.last   = 10'(code % 32'd1000);
    return res;
  endfunction

  // Search for a MAC whose raw hash code is banned is impractical, so the
  // rejection path is reached only if the random MACs happen to hit it; the
  // predictor still models it in full.
  function automatic logic [47:0] rand_mac();
    return {16'($urandom), $urandom};
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reset is held low from time zero and released on a falling edge.
  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // Stimulus: directed extremes first, then random requests. Most random
  // requests carry a valid MAC since the fallback path is a single case.
  initial begin
    mac_req_t r;
    pending_reqs.push_back('{mac: 48'h0, avail: 1'b1});
    pending_reqs.push_back('{mac: 48'hFFFF_FFFF_FFFF, avail: 1'b1});
    pending_reqs.push_back('{mac: 48'h0, avail: 1'b0});
    pending_reqs.push_back('{mac: 48'hFFFF_FFFF_FFFF, avail: 1'b0});
    pending_reqs.push_back('{mac: 48'hAAAA_AAAA_AAAA, avail: 1'b1});
    pending_reqs.push_back('{mac: 48'h5555_5555_5555, avail: 1'b1});
    pending_reqs.push_back('{mac: 48'hFF00_0000_0000, avail: 1'b1});
    pending_reqs.push_back('{mac: 48'h0000_0000_00FF, avail: 1'b1});
    for (int b = 0; b < 6; b++) begin
      pending_reqs.push_back('{mac: 48'h1 << (b * 8 + 7), avail: 1'b1});
    end
    pending_reqs.push_back('{mac: 48'h0200_0000_0001, avail: 1'b0});
    for (int n = 0; n < N_RANDOM; n++) begin
      r.mac   = rand_mac();
      r.avail = ($urandom_range(0, 9) != 0);
      pending_reqs.push_back(r);
    end
    wait (stim_done);
    wait (expected_codes.size() == 0);
    repeat (TRIES + 30) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Driver: bursts of back-to-back requests separated by random gaps. A
  // request stays on the port, unchanged, until it is accepted.
  int unsigned burst_left;
  int unsigned gap_left;
  mac_req_t    cur_req;

  initial begin
    in_valid         = 1'b0;
    in_mac_address   = '0;
    in_mac_available = 1'b0;
    out_stall        = 1'b0;
    stim_done        = 1'b0;
    burst_left       = 0;
    gap_left         = 0;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_fire) begin
        // Either the last request went in at the rising edge or nothing was
        // offered.
        if (gap_left > 0) begin
          gap_left   <= gap_left - 1;
          in_valid   <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          in_valid         <= 1'b1;
          in_mac_address   <= cur_req.mac;
          in_mac_available <= cur_req.avail;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 20);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid  <= 1'b0;
          stim_done <= 1'b1;
        end
      end
      // Receiver stall pattern: quiet stretches alternate with heavy stalling.
      if (($time / 2000) % 3 == 0) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 45);
      end
    end
  end

  // Monitor: records expectations at input acceptance and checks results.
  always @(posedge clk) begin
    setup_code_t got;
    setup_code_t want;
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_codes.push_back(predict_setup_code('{mac: in_mac_address,
                                                      avail: in_mac_available}));
      end
      if (out_valid && !out_stall) begin
        got = '{out_code_value, out_first_group, out_middle_group,
                out_last_group, out_used_fallback};
        if (expected_codes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: code %0d", out_code_value);
          end
        end else begin
          want = expected_codes.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: expected %0d %0d-%0d-%0d fb=%0b,",
                       want.code, want.first, want.middle, want.last,
                       want.fallback);
              $display("  got %0d %0d-%0d-%0d fb=%0b",
                       got.code, got.first, got.middle, got.last, got.fallback);
            end
          end
        end
      end
    end
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
